>>> src/tbpd_pkg.sv
// Shared types and constants for the tilt balance PID drive.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tbpd_pkg;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_BALANCE_POINT  = 3'd0,
		REG_FALL_MARGIN    = 3'd1,
		REG_KP             = 3'd2,
		REG_KI             = 3'd3,
		REG_KD             = 3'd4,
		REG_INTEGRAL_LIMIT = 3'd5,
		REG_DUTY_LIMIT     = 3'd6
	} reg_idx_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 20;

	// Register values after reset
	localparam logic signed [16:0] BALANCE_POINT_RST  = 17'sd1946;
	localparam logic        [15:0] FALL_MARGIN_RST    = 16'd1280;
	localparam logic        [19:0] KP_RST             = 20'd128000;
	localparam logic        [19:0] KI_RST             = 20'd7680;
	localparam logic        [19:0] KD_RST             = 20'd768;
	localparam logic        [15:0] INTEGRAL_LIMIT_RST = 16'd7680;
	localparam logic        [13:0] DUTY_LIMIT_RST     = 14'd5000;

	// Minimum drive rule: a small nonzero drive is raised to this magnitude
	localparam logic signed [30:0] MIN_DRIVE_EDGE  = 31'sd1000;
	localparam logic signed [30:0] MIN_DRIVE_VALUE = 31'sd800;

	typedef struct packed {
		logic signed [16:0] balance_point;
		logic        [15:0] fall_margin;
		logic        [19:0] kp;
		logic        [19:0] ki;
		logic        [19:0] kd;
		logic        [15:0] integral_limit;
		logic        [13:0] duty_limit;
	} cfg_t;

	// Angle error stage contents
	typedef struct packed {
		logic               fallen;
		logic signed [17:0] bias;
		logic signed [16:0] acc;
		logic signed [23:0] gyro;
	} err_t;

	// Product stage contents
	typedef struct packed {
		logic               fallen;
		logic signed [38:0] p_prop;
		logic signed [37:0] p_int;
		logic signed [44:0] p_rate;
	} prod_t;

endpackage

`default_nettype wire

>>> src/tbpd_cfg.sv
// Configuration register file of the tilt balance PID drive.
// Depends on tbpd_pkg for the register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module tbpd_cfg (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [tbpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [tbpd_pkg::CFG_DATA_W-1:0]       cfg_data,
	output      tbpd_pkg::cfg_t                        cfg
);

	tbpd_pkg::cfg_t cfg_q;

	// Writes are single beats, always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Decode index and store the written field; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.balance_point  <= tbpd_pkg::BALANCE_POINT_RST;
			cfg_q.fall_margin    <= tbpd_pkg::FALL_MARGIN_RST;
			cfg_q.kp             <= tbpd_pkg::KP_RST;
			cfg_q.ki             <= tbpd_pkg::KI_RST;
			cfg_q.kd             <= tbpd_pkg::KD_RST;
			cfg_q.integral_limit <= tbpd_pkg::INTEGRAL_LIMIT_RST;
			cfg_q.duty_limit     <= tbpd_pkg::DUTY_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (tbpd_pkg::reg_idx_t'(cfg_index))
				tbpd_pkg::REG_BALANCE_POINT:  cfg_q.balance_point  <= cfg_data[16:0];
				tbpd_pkg::REG_FALL_MARGIN:    cfg_q.fall_margin    <= cfg_data[15:0];
				tbpd_pkg::REG_KP:             cfg_q.kp             <= cfg_data[19:0];
				tbpd_pkg::REG_KI:             cfg_q.ki             <= cfg_data[19:0];
				tbpd_pkg::REG_KD:             cfg_q.kd             <= cfg_data[19:0];
				tbpd_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[15:0];
				tbpd_pkg::REG_DUTY_LIMIT:     cfg_q.duty_limit     <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/tbpd_track.sv
// Fall detection and clamped error integral, one beat per cycle unless the next stage stalls.
// Holds the integral and fall latch state; depends on tbpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbpd_track (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tbpd_pkg::cfg_t      cfg,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic signed [16:0]  angle,
	input  wire logic signed [23:0]  gyro,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      tbpd_pkg::err_t      err
);

	logic signed [16:0] integral_q;
	logic               fallen_q;
	logic               valid_s2;
	tbpd_pkg::err_t     err_s2;

	logic signed [17:0] band;
	logic signed [18:0] band_ext;
	logic signed [18:0] neg_band;
	logic signed [18:0] angle_ext;
	logic               fall_now;
	logic signed [17:0] bias;
	logic signed [18:0] sum;
	logic signed [18:0] lim;
	logic signed [18:0] clamped;

	// Band test: balance point plus margin, mirrored about zero on both sides
	always_comb begin
		band      = 18'(cfg.balance_point) + $signed({2'b00, cfg.fall_margin});
		band_ext  = 19'(band);
		neg_band  = -band_ext;
		angle_ext = 19'(angle);
		fall_now  = fallen_q || (angle_ext < neg_band) || (angle_ext > band_ext);
	end

	// Error and clamped integral
	always_comb begin
		bias = 18'(angle) - 18'(cfg.balance_point);
		sum  = 19'(integral_q) + 19'(bias);
		lim  = $signed({3'b000, cfg.integral_limit});
		if (sum > lim) begin
			clamped = lim;
		end else if (sum < -lim) begin
			clamped = -lim;
		end else begin
			clamped = sum;
		end
	end

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign err       = err_s2;

	// Update state as each beat passes; integral holds while fallen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			fallen_q   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (in_valid && in_ready) begin
				fallen_q <= fall_now;
				if (!fall_now) begin
					integral_q <= clamped[16:0];
				end
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			err_s2.fallen <= fall_now;
			err_s2.bias   <= bias;
			err_s2.acc    <= clamped[16:0];
			err_s2.gyro   <= gyro;
		end
	end

endmodule

`default_nettype wire

>>> src/tbpd_mul.sv
// Gain multiply stage: proportional, integral and rate products.
// Depends on tbpd_pkg for the stage structs and configuration.
`timescale 1ns / 1ps
`default_nettype none

module tbpd_mul (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tbpd_pkg::cfg_t  cfg,
	input  wire logic            in_valid,
	output      logic            in_ready,
	input  wire tbpd_pkg::err_t  err,
	output      logic            out_valid,
	input  wire logic            out_ready,
	output      tbpd_pkg::prod_t prod
);

	logic            valid_s3;
	tbpd_pkg::prod_t prod_s3;

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;
	assign prod      = prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// Three independent products, registered
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s3.fallen <= err.fallen;
			prod_s3.p_prop <= 39'($signed({1'b0, cfg.kp})) * 39'(err.bias);
			prod_s3.p_int  <= 38'($signed({1'b0, cfg.ki})) * 38'(err.acc);
			prod_s3.p_rate <= 45'($signed({1'b0, cfg.kd})) * 45'(err.gyro);
		end
	end

endmodule

`default_nettype wire

>>> src/tbpd_shape.sv
// Drive shaping: sum, scale, saturate, minimum magnitude, output register.
// Depends on tbpd_pkg for the product struct and drive constants.
`timescale 1ns / 1ps
`default_nettype none

module tbpd_shape (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tbpd_pkg::cfg_t  cfg,
	input  wire logic            in_valid,
	output      logic            in_ready,
	input  wire tbpd_pkg::prod_t prod,
	output      logic            out_valid,
	input  wire logic            out_ready,
	output      logic [13:0]     duty,
	output      logic            reverse,
	output      logic            fallen
);

	logic        valid_q;
	logic [13:0] duty_q;
	logic        reverse_q;
	logic        fallen_q;

	logic signed [45:0] sum;
	logic signed [29:0] scaled;
	logic signed [30:0] drive;
	logic signed [30:0] dl;
	logic signed [30:0] sat;
	logic signed [30:0] shaped;
	logic signed [30:0] mag;
	logic [13:0]        duty_d;
	logic               reverse_d;

	// Floor divide by 2^16 is an arithmetic shift; negate for drive
	always_comb begin
		sum    = 46'(prod.p_prop) + 46'(prod.p_int) + 46'(prod.p_rate);
		scaled = sum[45:16];
		drive  = -31'(scaled);
		dl     = $signed({17'b0, cfg.duty_limit});
		if (drive > dl) begin
			sat = dl;
		end else if (drive < -dl) begin
			sat = -dl;
		end else begin
			sat = drive;
		end
		// Raise small nonzero drive to the minimum magnitude
		if (sat < 0 && sat > -tbpd_pkg::MIN_DRIVE_EDGE) begin
			shaped = -tbpd_pkg::MIN_DRIVE_VALUE;
		end else if (sat > 0 && sat < tbpd_pkg::MIN_DRIVE_EDGE) begin
			shaped = tbpd_pkg::MIN_DRIVE_VALUE;
		end else begin
			shaped = sat;
		end
		mag = (shaped < 0) ? -shaped : shaped;
		if (prod.fallen) begin
			duty_d    = '0;
			reverse_d = 1'b0;
		end else begin
			duty_d    = mag[13:0];
			reverse_d = shaped[30];
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign duty      = duty_q;
	assign reverse   = reverse_q;
	assign fallen    = fallen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			duty_q    <= duty_d;
			reverse_q <= reverse_d;
			fallen_q  <= prod.fallen;
		end
	end

endmodule

`default_nettype wire

>>> src/tilt_balance_pid_drive.sv
// Top level of the tilt balance PID drive: stream ports, input register, stages.
// Depends on tbpd_pkg, tbpd_cfg, tbpd_track, tbpd_mul and tbpd_shape.
//
// One control tick per input beat: roll angle and gyro rate in, one drive
// command out. It takes a beat every cycle unless the output stalls; each
// beat passes the input register, fall test and clamped integral, gain
// multiplies and drive shaping into the output register. The integral and
// fall latch update as each beat is accepted, so ticks can follow back to
// back. Once the angle leaves the band of plus or minus balance point plus
// margin, the fallen flag sticks and the duty stays zero until reset. Write
// configuration only while no tick is in flight; writes to unused indexes are dropped.
`timescale 1ns / 1ps
`default_nettype none

module tilt_balance_pid_drive (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write channel
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [tbpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [tbpd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input stream
	input  wire logic                              s_axis_tvalid,
	output      logic                              s_axis_tready,
	input  wire logic [47:0]                       s_axis_tdata,  // angle[16:0], gyro_rate[40:17], zero
	// Output stream
	output      logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output      logic [15:0]                       m_axis_tdata   // duty[13:0], reverse[14], fallen[15]
);

	tbpd_pkg::cfg_t  cfg;
	tbpd_pkg::err_t  err;
	tbpd_pkg::prod_t prod;

	logic               valid_s1;
	logic signed [16:0] angle_s1;
	logic signed [23:0] gyro_s1;
	logic               track_ready;
	logic               err_valid;
	logic               mul_ready;
	logic               prod_valid;
	logic               shape_ready;
	logic [13:0]        duty;
	logic               reverse;
	logic               fallen;

	tbpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register
	assign s_axis_tready = !valid_s1 || track_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			angle_s1 <= s_axis_tdata[16:0];
			gyro_s1  <= s_axis_tdata[40:17];
		end
	end

	tbpd_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (valid_s1),
		.in_ready  (track_ready),
		.angle     (angle_s1),
		.gyro      (gyro_s1),
		.out_valid (err_valid),
		.out_ready (mul_ready),
		.err       (err)
	);

	tbpd_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (err_valid),
		.in_ready  (mul_ready),
		.err       (err),
		.out_valid (prod_valid),
		.out_ready (shape_ready),
		.prod      (prod)
	);

	tbpd_shape u_shape (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (prod_valid),
		.in_ready  (shape_ready),
		.prod      (prod),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.duty      (duty),
		.reverse   (reverse),
		.fallen    (fallen)
	);

	assign m_axis_tdata = {fallen, reverse, duty};

endmodule

`default_nettype wire

>>> tb/sv/tb_tilt_balance_pid_drive.sv
// Self-checking testbench for the tilt balance PID drive.
// Drives control ticks and register writes, predicts each drive command in
// place and checks every result beat; depends on tbpd_pkg and the block.
`timescale 1ns / 1ps

module tb_tilt_balance_pid_drive;

	localparam int          ANGLE_SPAN   = 46080;
	localparam int          DUTY_MAX     = 10000;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_LIMIT  = 20000;
	localparam logic [2:0]  REG_UNUSED   = 3'd7;

	typedef struct {
		logic [13:0] duty;
		logic        reverse;
		logic        fallen;
	} drive_cmd_t;

	logic                             clk           = 1'b0;
	logic                             arst_n        = 1'b0;
	logic                             cfg_valid     = 1'b0;
	wire logic                        cfg_ready;
	logic [tbpd_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [tbpd_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                             s_axis_tvalid = 1'b0;
	wire logic                        s_axis_tready;
	logic [47:0]                      s_axis_tdata  = '0;
	wire logic                        m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	wire logic [15:0]                 m_axis_tdata;

	// Register mirror
	longint zero_angle, fall_band, gain_p, gain_i, gain_d, integ_limit, duty_cap;
	// Controller state mirror
	longint integ_acc;
	bit     tilt_fallen;

	logic [47:0] tick_queue[$];
	drive_cmd_t  expected_cmds[$];
	int          ticks_offered  = 0;
	int          ticks_accepted = 0;
	int          mismatch_count = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          hold_token     = 0;
	int          hold_seen;
	int          hold_left;
	drive_cmd_t  want;

	tilt_balance_pid_drive i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Compute the drive command for one tick and advance the mirrored state
	function automatic drive_cmd_t drive_command_for(input logic [47:0] beat);
		longint     ang, gyr, band, bias, acc, sum, drv;
		drive_cmd_t cmd;
		ang = $signed(beat[16:0]);
		gyr = $signed(beat[40:17]);
		band = zero_angle + fall_band;
		cmd.duty = '0;
		cmd.reverse = 1'b0;
		cmd.fallen = 1'b0;
		if (ang < -band || ang > band)
			tilt_fallen = 1'b1;
		if (tilt_fallen) begin
			cmd.fallen = 1'b1;
			return cmd;
		end
		bias = ang - zero_angle;
		acc = integ_acc + bias;
		if (acc > integ_limit)
			acc = integ_limit;
		if (acc < -integ_limit)
			acc = -integ_limit;
		integ_acc = acc;
		sum = gain_p * bias + gain_i * acc + gain_d * gyr;
		drv = -(sum >>> 16);
		if (drv > duty_cap)
			drv = duty_cap;
		if (drv < -duty_cap)
			drv = -duty_cap;
		// Lift small nonzero drives to the minimum magnitude, sign kept
		if (drv < 0 && drv > -longint'(tbpd_pkg::MIN_DRIVE_EDGE))
			drv = -longint'(tbpd_pkg::MIN_DRIVE_VALUE);
		if (drv > 0 && drv < longint'(tbpd_pkg::MIN_DRIVE_EDGE))
			drv = longint'(tbpd_pkg::MIN_DRIVE_VALUE);
		cmd.reverse = (drv < 0);
		cmd.duty = (drv < 0) ? 14'(-drv) : 14'(drv);
		return cmd;
	endfunction

	// Input driver: offer pending ticks, predict on every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_cmds.push_back(drive_command_for(s_axis_tdata));
				ticks_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= tick_queue.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output ready: long hold-off on request, otherwise random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_seen     <= 0;
			hold_left     <= 0;
		end else if (hold_token != hold_seen) begin
			hold_seen     <= hold_token;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Result monitor: compare each beat with the oldest expected command
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_cmds.size() == 0) begin
				$error("result beat %h with no command expected", m_axis_tdata);
				mismatch_count++;
			end else begin
				want = expected_cmds.pop_front();
				if (m_axis_tdata[13:0] !== want.duty) begin
					$error("duty: expected %0d, actual %0d", want.duty, m_axis_tdata[13:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[14] !== want.reverse) begin
					$error("reverse: expected %0d, actual %0d", want.reverse, m_axis_tdata[14]);
					mismatch_count++;
				end
				if (m_axis_tdata[15] !== want.fallen) begin
					$error("fallen: expected %0d, actual %0d", want.fallen, m_axis_tdata[15]);
					mismatch_count++;
				end
			end
		end
	end

	// Write one register; call right after a rising edge while idle
	task automatic write_reg(input logic [2:0] idx, input longint val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[tbpd_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tbpd_pkg::REG_BALANCE_POINT:  zero_angle  = $signed(val[16:0]);
			tbpd_pkg::REG_FALL_MARGIN:    fall_band   = val[15:0];
			tbpd_pkg::REG_KP:             gain_p      = val[19:0];
			tbpd_pkg::REG_KI:             gain_i      = val[19:0];
			tbpd_pkg::REG_KD:             gain_d      = val[19:0];
			tbpd_pkg::REG_INTEGRAL_LIMIT: integ_limit = val[15:0];
			tbpd_pkg::REG_DUTY_LIMIT:     duty_cap    = val[13:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input longint az, input longint fm, input longint p,
			input longint i, input longint d, input longint il, input longint dl);
		write_reg(tbpd_pkg::REG_BALANCE_POINT, az);
		write_reg(tbpd_pkg::REG_FALL_MARGIN, fm);
		write_reg(tbpd_pkg::REG_KP, p);
		write_reg(tbpd_pkg::REG_KI, i);
		write_reg(tbpd_pkg::REG_KD, d);
		write_reg(tbpd_pkg::REG_INTEGRAL_LIMIT, il);
		write_reg(tbpd_pkg::REG_DUTY_LIMIT, dl);
	endtask

	task automatic queue_tick(input int ang, input int gyr);
		tick_queue.push_back({7'd0, 24'(gyr), 17'(ang)});
		ticks_offered++;
	endtask

	// Wait until every tick is accepted and answered, then let the pipe empty
	task automatic settle();
		int waited;
		waited = 0;
		while ((ticks_accepted != ticks_offered || expected_cmds.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_cmds.size() != 0) begin
			$error("%0d drive commands never arrived", expected_cmds.size());
			mismatch_count += expected_cmds.size();
			expected_cmds.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	function automatic int rand_gain();
		return int'($urandom & ((32'd1 << $urandom_range(20, 0)) - 1));
	endfunction

	function automatic int rand_gyro();
		logic signed [23:0] g;
		g = 24'($urandom);
		return int'(g >>> $urandom_range(23, 0));
	endfunction

	// Random settings with a band that is never negative
	task automatic pick_settings();
		int az, fm;
		if ($urandom_range(3) == 0)
			az = int'($urandom_range(2 * ANGLE_SPAN)) - ANGLE_SPAN;
		else
			az = int'($urandom_range(6000)) - 3000;
		if (az < 0)
			fm = $urandom_range(ANGLE_SPAN, -az);
		else
			fm = $urandom_range(ANGLE_SPAN);
		write_all(az, fm, rand_gain(), rand_gain(), rand_gain(), $urandom_range(65535),
			($urandom_range(3) == 0) ? $urandom_range(1200) : $urandom_range(DUTY_MAX));
	endtask

	// Random ticks kept inside the safe band, often near the balance point
	task automatic run_upright(input int count);
		int lo, hi, ang;
		lo = int'(-(zero_angle + fall_band));
		hi = int'(zero_angle + fall_band);
		if (lo < -ANGLE_SPAN)
			lo = -ANGLE_SPAN;
		if (hi > ANGLE_SPAN)
			hi = ANGLE_SPAN;
		for (int n = 0; n < count; n++) begin
			ang = lo + int'($urandom_range(hi - lo));
			if ($urandom_range(2) == 0) begin
				ang = int'(zero_angle) + int'($urandom_range(400)) - 200;
				if (ang < lo)
					ang = lo;
				if (ang > hi)
					ang = hi;
			end
			queue_tick(ang, rand_gyro());
		end
	endtask

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		zero_angle  = tbpd_pkg::BALANCE_POINT_RST;
		fall_band   = tbpd_pkg::FALL_MARGIN_RST;
		gain_p      = tbpd_pkg::KP_RST;
		gain_i      = tbpd_pkg::KI_RST;
		gain_d      = tbpd_pkg::KD_RST;
		integ_limit = tbpd_pkg::INTEGRAL_LIMIT_RST;
		duty_cap    = tbpd_pkg::DUTY_LIMIT_RST;
		integ_acc   = 0;
		tilt_fallen = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Reset settings: balance point, band edges, gyro extremes
		queue_tick(1946, 0);
		queue_tick(3226, 0);
		queue_tick(-3226, 0);
		queue_tick(1946, 8388607);
		queue_tick(1946, -8388608);
		queue_tick(1950, 0);
		settle();

		// Widest band and largest gains: angle extremes, integral clamp
		write_all(ANGLE_SPAN, 0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 65535, DUTY_MAX);
		queue_tick(-ANGLE_SPAN, -8388608);
		queue_tick(ANGLE_SPAN, 8388607);
		queue_tick(ANGLE_SPAN, 0);
		queue_tick(0, 0);
		settle();

		// Proportional gain of 256 (a scale of 1/256), no integral: small drives lifted to the minimum
		write_all(0, ANGLE_SPAN, 256, 0, 0, 0, DUTY_MAX);
		queue_tick(0, 0);
		queue_tick(1, 0);
		queue_tick(-1, 0);
		queue_tick(ANGLE_SPAN, 0);
		queue_tick(-ANGLE_SPAN, 0);
		settle();

		// Duty limit below the minimum edge, then zero
		write_reg(tbpd_pkg::REG_KP, 20'hFFFFF);
		write_reg(tbpd_pkg::REG_DUTY_LIMIT, 500);
		queue_tick(1000, 0);
		queue_tick(-1000, 0);
		settle();
		write_reg(tbpd_pkg::REG_DUTY_LIMIT, 0);
		queue_tick(1000, 0);
		queue_tick(-1000, 0);
		settle();

		// Write to an unused index: no effect
		write_reg(REG_UNUSED, 20'hFFFFF);
		queue_tick(-2000, 123456);
		settle();

		// Random phases: none, sender idle, receiver stalls, both
		for (int mode = 0; mode < 4; mode++) begin
			send_idle_pct  = (mode == 1) ? 61 : (mode == 3) ? 23 : 0;
			recv_stall_pct = (mode == 2) ? 61 : (mode == 3) ? 23 : 0;
			for (int k = 0; k < 2; k++) begin
				pick_settings();
				run_upright(45);
				settle();
			end
		end

		// Receiver holds off while the sender keeps offering
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		pick_settings();
		hold_token++;
		run_upright(50);
		settle();

		// Negative band: any angle falls, and the flag sticks
		send_idle_pct  = 23;
		recv_stall_pct = 23;
		write_reg(tbpd_pkg::REG_BALANCE_POINT, -2000);
		write_reg(tbpd_pkg::REG_FALL_MARGIN, 1000);
		queue_tick(0, 0);
		settle();
		pick_settings();
		for (int n = 0; n < 20; n++)
			queue_tick(int'($urandom_range(2 * ANGLE_SPAN)) - ANGLE_SPAN, rand_gyro());
		settle();

		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
